/* rtl/ccl_pkg.sv */
`timescale 1ns / 1ps

package ccl_pkg;

    localparam int MAX_NODES_DEFAULT = 16;
    localparam int MASK_W = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int NODE_LIMIT = 16;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 5'd10;

    typedef struct packed {
        logic load;
        logic start_run;
        logic scan_skip;
        logic scan_open;
        logic rewind;
        logic pop;
        logic expand;
        logic close_comp;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic node_visited;
        logic frontier_empty;
        logic emit_last;
    } status_t;

endpackage

/* rtl/connected_component_labeler.sv */
`timescale 1ns / 1ps
// Rows load at one item per cycle while busy is low; an item without last_row leaves busy low.
// After the last row, the walk scans each node in turn, pops and expands every node of a
// component, and closes each component; then n results follow, one per node.
// busy stays high until the final label read; the receiver cannot stall the results.
// Reset is asynchronous, active low: node_count returns to 10 and all control clears.

module connected_component_labeler
#(
    parameter int MAX_NODES = ccl_pkg::MAX_NODES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ccl_pkg::IDX_W-1:0]   row_index,
    input  logic [ccl_pkg::MASK_W-1:0]  row_bits,
    input  logic                        last_row,
    input  logic                        node_count_we,
    input  logic [ccl_pkg::CNT_W-1:0]   node_count_wdata,
    output logic                        result_valid,
    output logic [ccl_pkg::IDX_W-1:0]   node_index,
    output logic [ccl_pkg::IDX_W-1:0]   component_id,
    output logic [ccl_pkg::CNT_W-1:0]   component_count,
    output logic                        last_result
);

    ccl_pkg::cmd_t    cmd;
    ccl_pkg::status_t status;

    ccl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_row (last_row),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    ccl_datapath
    #(
        .MAX_NODES (MAX_NODES)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .row_index        (row_index),
        .row_bits         (row_bits),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .result_valid     (result_valid),
        .node_index       (node_index),
        .component_id     (component_id),
        .component_count  (component_count),
        .last_result      (last_result)
    );

endmodule

/* rtl/ccl_ctrl.sv */
`timescale 1ns / 1ps

module ccl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_row,
    input  ccl_pkg::status_t  status,
    output ccl_pkg::cmd_t     cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_EXPAND,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_row)
                    begin
                        cmd.start_run = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.rewind = 1'b1;
                    state_next = ST_OUT;
                end
                else if (status.node_visited)
                begin
                    cmd.scan_skip = 1'b1;
                end
                else
                begin
                    cmd.scan_open = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (status.frontier_empty)
                begin
                    cmd.close_comp = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    state_next = ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                cmd.expand = 1'b1;
                state_next = ST_POP;
            end
            ST_OUT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* rtl/ccl_datapath.sv */
`timescale 1ns / 1ps

module ccl_datapath
#(
    parameter int MAX_NODES = ccl_pkg::MAX_NODES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ccl_pkg::cmd_t               cmd,
    output ccl_pkg::status_t            status,
    input  logic [ccl_pkg::IDX_W-1:0]   row_index,
    input  logic [ccl_pkg::MASK_W-1:0]  row_bits,
    input  logic                        node_count_we,
    input  logic [ccl_pkg::CNT_W-1:0]   node_count_wdata,
    output logic                        result_valid,
    output logic [ccl_pkg::IDX_W-1:0]   node_index,
    output logic [ccl_pkg::IDX_W-1:0]   component_id,
    output logic [ccl_pkg::CNT_W-1:0]   component_count,
    output logic                        last_result
);

    localparam int LIMIT = (MAX_NODES < ccl_pkg::NODE_LIMIT) ? MAX_NODES : ccl_pkg::NODE_LIMIT;
    localparam int AW = $clog2(LIMIT);
    localparam int MW = ccl_pkg::MASK_W;
    localparam int IW = ccl_pkg::IDX_W;
    localparam int CW = ccl_pkg::CNT_W;

    logic [MW-1:0] adj_mem [LIMIT];
    logic [IW-1:0] lbl_mem [LIMIT];

    logic [CW-1:0] node_count_reg;
    logic [MW-1:0] vis_reg;
    logic [MW-1:0] vis_next;
    logic [MW-1:0] fr_reg;
    logic [MW-1:0] fr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          valid_reg;

    logic [MW-1:0] adj_rd_reg;
    logic [IW-1:0] lbl_rd_reg;
    logic [IW-1:0] node_index_reg;
    logic [CW-1:0] count_out_reg;
    logic          last_reg;

    logic [CW-1:0] n_eff;
    logic [MW-1:0] in_use;
    logic [IW-1:0] low_f;
    logic [MW-1:0] nb;
    logic          row_in_range;

    function automatic logic [IW-1:0] lowest_set(input logic [MW-1:0] m);
        logic [IW-1:0] k;
        k = '0;
        for (int j = MW - 1; j >= 0; j--)
        begin
            if (m[j])
            begin
                k = IW'(j);
            end
        end
        return k;
    endfunction

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (node_count_reg > CW'(ccl_pkg::NODE_LIMIT))
        begin
            n_eff = CW'(ccl_pkg::NODE_LIMIT);
        end
        else
        begin
            n_eff = node_count_reg;
        end
        if (n_eff > CW'(LIMIT))
        begin
            n_eff = CW'(LIMIT);
        end
    end

    always_comb
    begin
        for (int j = 0; j < MW; j++)
        begin
            in_use[j] = (CW'(j) < n_eff);
        end
    end

    assign low_f = lowest_set(fr_reg);
    assign nb = adj_rd_reg & in_use & ~vis_reg;
    assign row_in_range = ({1'b0, row_index} < n_eff);

    always_comb
    begin
        vis_next = vis_reg;
        fr_next = fr_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.start_run)
        begin
            vis_next = '0;
            fr_next = '0;
            cnt_next = '0;
            idx_next = '0;
        end
        if (cmd.scan_skip || cmd.emit)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.scan_open)
        begin
            vis_next = vis_reg | (MW'(1) << idx_reg[IW-1:0]);
            fr_next = MW'(1) << idx_reg[IW-1:0];
        end
        if (cmd.rewind)
        begin
            idx_next = '0;
        end
        if (cmd.pop)
        begin
            fr_next = fr_reg & ~(MW'(1) << low_f);
        end
        if (cmd.expand)
        begin
            vis_next = vis_reg | nb;
            fr_next = fr_reg | nb;
        end
        if (cmd.close_comp)
        begin
            cnt_next = cnt_reg + CW'(1);
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ccl_pkg::NODE_COUNT_RESET;
            vis_reg <= '0;
            fr_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
            vis_reg <= vis_next;
            fr_reg <= fr_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && row_in_range)
        begin
            adj_mem[row_index[AW-1:0]] <= row_bits;
        end
        if (cmd.pop)
        begin
            adj_rd_reg <= adj_mem[low_f[AW-1:0]];
            lbl_mem[low_f[AW-1:0]] <= cnt_reg[IW-1:0];
        end
        if (cmd.emit)
        begin
            lbl_rd_reg <= lbl_mem[idx_reg[AW-1:0]];
            node_index_reg <= idx_reg[IW-1:0];
            last_reg <= status.emit_last;
            count_out_reg <= status.emit_last ? cnt_reg : '0;
        end
    end

    assign status.scan_done = (idx_reg >= n_eff);
    assign status.node_visited = vis_reg[idx_reg[IW-1:0]];
    assign status.frontier_empty = (fr_reg == '0);
    assign status.emit_last = (idx_reg == n_eff - CW'(1));

    assign result_valid = valid_reg;
    assign node_index = node_index_reg;
    assign component_id = lbl_rd_reg;
    assign component_count = count_out_reg;
    assign last_result = last_reg;

endmodule

/* sim/tb_connected_component_labeler.sv */
`timescale 1ns / 1ps

module tb_connected_component_labeler;

    localparam int QUIET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 180;

    typedef enum logic {ENTRY_ROW, ENTRY_CFG} entry_kind_t;

    typedef struct {
        entry_kind_t                kind;
        logic [ccl_pkg::IDX_W-1:0]  ridx;
        logic [ccl_pkg::MASK_W-1:0] bits;
        logic                       last;
        logic [ccl_pkg::CNT_W-1:0]  cfg;
    } stim_entry_t;

    typedef struct {
        logic [ccl_pkg::IDX_W-1:0] node;
        logic [ccl_pkg::IDX_W-1:0] comp;
        logic [ccl_pkg::CNT_W-1:0] count;
        logic                      last;
    } label_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [ccl_pkg::IDX_W-1:0] row_index = '0;
    logic [ccl_pkg::MASK_W-1:0] row_bits = '0;
    logic last_row = 1'b0;
    logic node_count_we = 1'b0;
    logic [ccl_pkg::CNT_W-1:0] node_count_wdata = '0;
    logic result_valid;
    logic [ccl_pkg::IDX_W-1:0] node_index;
    logic [ccl_pkg::IDX_W-1:0] component_id;
    logic [ccl_pkg::CNT_W-1:0] component_count;
    logic last_result;

    stim_entry_t   pending_q[$];
    label_result_t label_q[$];

    logic [ccl_pkg::CNT_W-1:0]  model_count = ccl_pkg::NODE_COUNT_RESET;
    logic [ccl_pkg::MASK_W-1:0] model_rows[16];
    logic [ccl_pkg::IDX_W-1:0]  model_labels[16];

    int gen_nodes;
    logic [15:0] gen_written;
    int gen_items;

    int error_count = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int runs_seen = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    int quiet = 0;
    int burst_left = 1;
    int gap_left = 0;

    connected_component_labeler i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .row_index        (row_index),
        .row_bits         (row_bits),
        .last_row         (last_row),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .result_valid     (result_valid),
        .node_index       (node_index),
        .component_id     (component_id),
        .component_count  (component_count),
        .last_result      (last_result)
    );

    always #6 clk = ~clk;

    function automatic int eff_nodes(input logic [ccl_pkg::CNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > ccl_pkg::NODE_LIMIT)
        begin
            n = ccl_pkg::NODE_LIMIT;
        end
        return n;
    endfunction

    function automatic logic [ccl_pkg::MASK_W-1:0] rand_row();
        logic [ccl_pkg::MASK_W-1:0] r;
        case ($urandom_range(0, 4))
            0: r = 16'($urandom);
            1: r = '0;
            2: r = 16'd1 << $urandom_range(0, 15);
            default: r = 16'($urandom & $urandom & $urandom);
        endcase
        return r;
    endfunction

    function automatic logic [ccl_pkg::CNT_W-1:0] pick_count();
        logic [ccl_pkg::CNT_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 5'd0;
            1: v = 5'd31;
            2: v = 5'd16;
            3: v = 5'($urandom_range(17, 30));
            default: v = 5'($urandom_range(1, 15));
        endcase
        return v;
    endfunction

    task automatic push_cfg(input logic [ccl_pkg::CNT_W-1:0] v);
        stim_entry_t e;
        e = '{ENTRY_CFG, '0, '0, 1'b0, v};
        pending_q.push_back(e);
        gen_nodes = eff_nodes(v);
    endtask

    task automatic push_row(input int idx, input logic [ccl_pkg::MASK_W-1:0] bits,
                            input logic last);
        stim_entry_t e;
        e = '{ENTRY_ROW, 4'(idx), bits, last, '0};
        pending_q.push_back(e);
        if (idx < gen_nodes)
        begin
            gen_written[idx] = 1'b1;
        end
        gen_items++;
    endtask

    // A run rewrites a random subset of the rows in shuffled order, always including any row
    // not yet written, with ignored out-of-range rows mixed in.
    task automatic make_run(input bit full);
        int order[16];
        int cnt;
        int a;
        int b;
        int t;
        cnt = 0;
        for (a = 0; a < gen_nodes; a++)
        begin
            if (full || !gen_written[a] || $urandom_range(0, 3) == 0)
            begin
                order[cnt] = a;
                cnt++;
            end
        end
        for (a = cnt - 1; a > 0; a--)
        begin
            b = $urandom_range(0, a);
            t = order[a];
            order[a] = order[b];
            order[b] = t;
        end
        for (a = 0; a < cnt - 1; a++)
        begin
            if (gen_nodes < 16 && $urandom_range(0, 7) == 0)
            begin
                push_row($urandom_range(gen_nodes, 15), 16'($urandom), 1'b0);
            end
            push_row(order[a], rand_row(), 1'b0);
        end
        if (cnt > 0)
        begin
            push_row(order[cnt - 1], rand_row(), 1'b1);
        end
        else if (gen_nodes < 16 && $urandom_range(0, 1) == 0)
        begin
            push_row($urandom_range(gen_nodes, 15), 16'($urandom), 1'b1);
        end
        else
        begin
            push_row($urandom_range(0, gen_nodes - 1), rand_row(), 1'b1);
        end
    endtask

    task automatic predict_item(input logic [ccl_pkg::IDX_W-1:0] ridx,
                                input logic [ccl_pkg::MASK_W-1:0] rbits,
                                input logic lr);
        int n;
        int i;
        int f;
        logic [ccl_pkg::MASK_W-1:0] in_use;
        logic [ccl_pkg::MASK_W-1:0] visited;
        logic [ccl_pkg::MASK_W-1:0] frontier;
        logic [ccl_pkg::MASK_W-1:0] nb;
        logic [ccl_pkg::CNT_W-1:0] count;
        label_result_t res;
        n = eff_nodes(model_count);
        if (ridx < n)
        begin
            model_rows[ridx] = rbits;
        end
        if (lr)
        begin
            in_use = 16'((17'd1 << n) - 17'd1);
            visited = '0;
            count = '0;
            for (i = 0; i < n; i++)
            begin
                if (!visited[i])
                begin
                    visited[i] = 1'b1;
                    frontier = '0;
                    frontier[i] = 1'b1;
                    while (frontier != '0)
                    begin
                        f = 0;
                        while (!frontier[f])
                        begin
                            f++;
                        end
                        frontier[f] = 1'b0;
                        model_labels[f] = count[ccl_pkg::IDX_W-1:0];
                        nb = model_rows[f] & in_use & ~visited;
                        visited = visited | nb;
                        frontier = frontier | nb;
                    end
                    count = count + 5'd1;
                end
            end
            for (i = 0; i < n; i++)
            begin
                res.node = 4'(i);
                res.comp = model_labels[i];
                res.count = (i == n - 1) ? count : '0;
                res.last = (i == n - 1);
                label_q.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic nxt_start;
        logic nxt_we;
        stim_entry_t e;
        if (!rst_n)
        begin
            start <= 1'b0;
            node_count_we <= 1'b0;
            node_count_wdata <= '0;
            row_index <= '0;
            row_bits <= '0;
            last_row <= 1'b0;
        end
        else
        begin
            nxt_start = start;
            nxt_we = 1'b0;
            if ((start && !busy) || result_valid)
            begin
                quiet <= 0;
            end
            else if (quiet < 1000)
            begin
                quiet <= quiet + 1;
            end
            if (start && busy)
            begin
                nxt_start = 1'b1;
            end
            else if (gap_left != 0)
            begin
                nxt_start = 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_q.size() == 0)
            begin
                nxt_start = 1'b0;
            end
            else if (pending_q[0].kind == ENTRY_CFG)
            begin
                nxt_start = 1'b0;
                if (label_q.size() == 0 && !busy && !start && quiet >= QUIET_CYCLES)
                begin
                    e = pending_q.pop_front();
                    nxt_we = 1'b1;
                    node_count_wdata <= e.cfg;
                    cfg_writes++;
                end
            end
            else
            begin
                e = pending_q.pop_front();
                row_index <= e.ridx;
                row_bits <= e.bits;
                last_row <= e.last;
                nxt_start = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            start <= nxt_start;
            node_count_we <= nxt_we;
        end
    end

    always @(posedge clk)
    begin : predictor
        if (rst_n)
        begin
            if (node_count_we)
            begin
                model_count = node_count_wdata;
            end
            if (start && !busy)
            begin
                predict_item(row_index, row_bits, last_row);
                items_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        label_result_t exp_res;
        if (rst_n && result_valid)
        begin
            if (label_q.size() == 0)
            begin
                $display("%0t ns: unexpected result for node %0d, expected none, actual id %0d",
                         $time, node_index, component_id);
                error_count++;
            end
            else
            begin
                exp_res = label_q.pop_front();
                check_field("node_index", int'(exp_res.node), int'(node_index));
                check_field("component_id", int'(exp_res.comp), int'(component_id));
                check_field("component_count", int'(exp_res.count), int'(component_count));
                check_field("last_result", int'(exp_res.last), int'(last_result));
                results_checked++;
                if (last_result)
                begin
                    runs_seen++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        gen_nodes = eff_nodes(ccl_pkg::NODE_COUNT_RESET);
        gen_written = '0;
        gen_items = 0;

        // One node with a full row: the self loop and all upper bits are ignored.
        push_cfg(5'd1);
        push_row(0, 16'hFFFF, 1'b1);
        // A zero count saturates to one; an out-of-range row still starts the run.
        push_cfg(5'd0);
        push_row(15, 16'h0000, 1'b1);
        // All sixteen nodes in a forward-only chain form one component.
        push_cfg(5'd16);
        for (i = 0; i < 16; i++)
        begin
            push_row(i, (i < 15) ? (16'd1 << (i + 1)) : 16'h0000, i == 15);
        end
        // An oversize count saturates to sixteen; cutting the chain gives two components.
        push_cfg(5'd31);
        push_row(3, 16'h0000, 1'b1);
        // Backward-only edges do not merge components; bits above the count are ignored.
        push_cfg(5'd4);
        push_row(0, 16'h0000, 1'b0);
        push_row(1, 16'h0001, 1'b0);
        push_row(2, 16'hFFF0, 1'b0);
        push_row(3, 16'h0004, 1'b1);

        while (gen_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                push_cfg(pick_count());
                make_run($urandom_range(0, 2) != 0);
            end
            else
            begin
                make_run($urandom_range(0, 3) == 0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (label_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d row items and %0d node count writes over %0d labeling runs.",
                 items_accepted, cfg_writes, runs_seen);
        $display("Checked %0d node labels in %0d cycles.", results_checked, cycle_count);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
